[rtl/rjd_pkg.sv]
`default_nettype none
package rjd_pkg;

  localparam int unsigned FlowW   = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned InsideW = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned RegionW = 3;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 56;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE_MASK = 2'd0,
    CFG_LIMITS_LO   = 2'd1,
    CFG_LIMITS_HI   = 2'd2
  } rjd_cfg_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_DETECTED = 2'd1,
    EV_CLEARED  = 2'd2
  } rjd_event_e;

  typedef struct packed {
    logic [FlowW-1:0]  last_flow;
    logic [TimeW-1:0]  last_change;
    logic              jammed;
    logic [CountW-1:0] jam_cnt;
  } rjd_entry_t;

  typedef struct packed {
    logic [FlowW-1:0]   flow;
    logic [InsideW-1:0] occupancy;
    logic [TimeW-1:0]   now;
    logic [LimitW-1:0]  limit;
  } rjd_report_t;

  typedef struct packed {
    logic [TimeW-1:0] stale;
    rjd_event_e       event_code;
  } rjd_verdict_t;

endpackage
`default_nettype wire

[rtl/rjd_state_mem.sv]
`default_nettype none
module rjd_state_mem
  import rjd_pkg::*;
#(
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output rjd_entry_t            rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire rjd_entry_t       wr_data_i
);

  rjd_entry_t             mem [Depth];
  logic [Depth-1:0]       valid_q;
  rjd_entry_t             rd_data_q;
  logic [AddrW-1:0]       rd_addr_q;
  logic                   lw_valid_q;
  logic [AddrW-1:0]       lw_addr_q;
  rjd_entry_t             lw_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem[rd_addr_i] : '0;
      rd_addr_q <= rd_addr_i;
    end
    if (wr_en_i) begin
      lw_addr_q <= wr_addr_i;
      lw_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      lw_valid_q <= 1'b0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
      lw_valid_q         <= 1'b1;
    end
  end

  // forward the newest write over a read that raced it
  assign rd_data_o = (lw_valid_q && (lw_addr_q == rd_addr_q)) ? lw_data_q : rd_data_q;

endmodule
`default_nettype wire

[rtl/rjd_update.sv]
`default_nettype none
module rjd_update
  import rjd_pkg::*;
(
  input  wire rjd_entry_t  entry_i,
  input  wire rjd_report_t report_i,
  output rjd_entry_t       entry_o,
  output rjd_verdict_t     verdict_o
);

  logic             changed;
  logic [TimeW-1:0] stale;
  logic             should;

  assign changed = (report_i.flow != entry_i.last_flow);
  assign stale   = changed ? '0 : (report_i.now - entry_i.last_change);
  assign should  = (report_i.occupancy != '0) &&
                   (stale >= {{(TimeW-LimitW){1'b0}}, report_i.limit});

  always_comb begin
    entry_o              = entry_i;
    verdict_o.stale      = stale;
    verdict_o.event_code = EV_NONE;
    if (changed) begin
      entry_o.last_flow   = report_i.flow;
      entry_o.last_change = report_i.now;
    end
    if (should && !entry_i.jammed) begin
      entry_o.jammed       = 1'b1;
      verdict_o.event_code = EV_DETECTED;
      if (entry_i.jam_cnt != '1) begin
        entry_o.jam_cnt = entry_i.jam_cnt + 1'b1;
      end
    end else if (!should && entry_i.jammed) begin
      entry_o.jammed       = 1'b0;
      verdict_o.event_code = EV_CLEARED;
    end
  end

endmodule
`default_nettype wire

[rtl/region_jam_detector.sv]
// Per-region stall watchdog. Each request reports one region's flow count,
// occupancy and a millisecond timestamp; the block keeps per-region state
// (last flow count, time of last change, jam flag, saturating jam count) in a
// small synchronous memory and returns one result per request. An enabled
// region yields the stale time and a detected/cleared event when its jam flag
// changes; a disabled or out-of-range region passes through with all result
// fields but the region zero. Throughput is one request per clock. The memory
// read is launched at the edge that accepts a request; the update, write-back
// and output register load happen at the edge on which stage 1 advances. A
// write-back register forwards the newest entry to a request for the same
// region that follows directly behind. The input stalls only while a result
// waits in the output register and stage 1 is full. Configuration writes are
// registered and must only be issued while the block is idle.
`default_nettype none
module region_jam_detector
  import rjd_pkg::*;
#(
  parameter int unsigned NUM_REGIONS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // region_index[2:0], flow_count[34:3], inside_count[50:35], now_ms[82:51]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // region_out[2:0], tracked[3], jam_active[4], jam_total[20:5],
  // stale_ms[52:21], event_code[54:53]
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam logic [RegionW:0] NumRegions = (RegionW+1)'(NUM_REGIONS);

  // configuration
  logic [MaskW-1:0]    enable_mask_q;
  logic [CfgDataW-1:0] limits_lo_q;
  logic [CfgDataW-1:0] limits_hi_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_mask_q <= '0;
      limits_lo_q   <= '0;
      limits_hi_q   <= '0;
    end else if (cfg_valid_i) begin
      case (rjd_cfg_e'(cfg_index_i))
        CFG_ENABLE_MASK: enable_mask_q <= cfg_data_i[MaskW-1:0];
        CFG_LIMITS_LO:   limits_lo_q   <= cfg_data_i;
        CFG_LIMITS_HI:   limits_hi_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input unpacking
  logic [RegionW-1:0] in_region;
  assign in_region = s_axis_tdata[RegionW-1:0];

  // stage 1: memory read in flight
  logic               s1_valid_q;
  logic [RegionW-1:0] s1_region_q;
  logic [FlowW-1:0]   s1_flow_q;
  logic [InsideW-1:0] s1_inside_q;
  logic [TimeW-1:0]   s1_now_q;
  logic               s1_adv;
  logic               accept;
  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_region_q <= in_region;
      s1_flow_q   <= s_axis_tdata[RegionW +: FlowW];
      s1_inside_q <= s_axis_tdata[RegionW+FlowW +: InsideW];
      s1_now_q    <= s_axis_tdata[RegionW+FlowW+InsideW +: TimeW];
    end
  end

  // state memory and update
  rjd_entry_t   rd_entry;
  rjd_entry_t   wr_entry;
  rjd_report_t  report;
  rjd_verdict_t verdict;
  logic         enabled;
  logic         wr_en;
  logic [CfgDataW-1:0] limit_word;

  assign enabled = ({1'b0, s1_region_q} < NumRegions) && enable_mask_q[s1_region_q];
  assign wr_en   = s1_adv && enabled;

  assign limit_word       = s1_region_q[2] ? limits_hi_q : limits_lo_q;
  assign report.flow      = s1_flow_q;
  assign report.occupancy = s1_inside_q;
  assign report.now       = s1_now_q;
  assign report.limit     = limit_word[{s1_region_q[1:0], 4'd0} +: LimitW];

  rjd_state_mem #(
    .Depth (NUM_REGIONS),
    .AddrW (AddrW)
  ) u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_region[AddrW-1:0]),
    .rd_data_o (rd_entry),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_region_q[AddrW-1:0]),
    .wr_data_i (wr_entry)
  );

  rjd_update u_update (
    .entry_i   (rd_entry),
    .report_i  (report),
    .entry_o   (wr_entry),
    .verdict_o (verdict)
  );

  // output register
  logic [OutDataW-1:0] result;

  always_comb begin
    result = '0;
    result[RegionW-1:0] = s1_region_q;
    if (enabled) begin
      result[RegionW]                        = 1'b1;
      result[RegionW+1]                      = wr_entry.jammed;
      result[RegionW+2 +: CountW]            = wr_entry.jam_cnt;
      result[RegionW+2+CountW +: TimeW]      = verdict.stale;
      result[RegionW+2+CountW+TimeW +: 2]    = verdict.event_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire
